// ===== hw/rtl/mcbq_pkg.sv =====
// Package for the multichannel biquad filter: field widths, register indexes
// and action codes. No dependencies.
package mcbq_pkg;

  // Fixed field widths
  localparam int COEF_BITS    = 32;
  localparam int CHAN_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;

  // Coefficient register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FEED0 = 3'd0,
    REG_FEED1 = 3'd1,
    REG_FEED2 = 3'd2,
    REG_BACK1 = 3'd3,
    REG_BACK2 = 3'd4
  } cfg_reg_t;

  // Item action codes
  typedef enum logic {
    ACT_FILTER = 1'b0,
    ACT_CLEAR  = 1'b1
  } action_t;

endpackage

// ===== hw/rtl/multichannel_biquad_filter.sv =====
// Multichannel direct form I biquad: coefficient registers, per-channel
// history and a one-pass multiply/sum/round/saturate datapath.
// Depends on mcbq_pkg.
//
//  channel  signals                                   direction
//  in       in_valid, in_stall, action, channel,      item in
//           sample_in
//  out      out_valid, out_stall, channel_out,        result out
//           sample_out, clipped
//  config   wr_en, wr_index, wr_data                  register write
//
// One item per cycle sustained while the output is not stalled; a filter item's
// result goes into the output register as the item leaves the input register.
// History is written as an item leaves the input register, so the next item on
// the same channel sees it without a bubble. Reset restores default coefficients
// and zeroes all history. A stalled output holds its result; one more item is
// taken into the input register, then in_stall rises. Clear items give no result.
module multichannel_biquad_filter
  import mcbq_pkg::*;
#(
  parameter int NUM_CHANNELS   = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [CHAN_BITS-1:0]          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHAN_BITS-1:0]          channel_out,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped,
  // configuration
  input  logic                          wr_en,
  input  logic [CFG_IDX_BITS-1:0]       wr_index,
  input  logic [COEF_BITS-1:0]          wr_data
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 3;

  localparam logic [COEF_BITS-1:0] FEED0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) << (SAMPLE_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

  // coefficient registers
  logic signed [COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= FEED0_RESET;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FEED0: coef_b0 <= wr_data;
        REG_FEED1: coef_b1 <= wr_data;
        REG_FEED2: coef_b2 <= wr_data;
        REG_BACK1: coef_a1 <= wr_data;
        REG_BACK2: coef_a2 <= wr_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                          s1_valid;
  logic                          s1_action;
  logic [CHAN_BITS-1:0]          s1_chan;
  logic signed [SAMPLE_BITS-1:0] s1_sample;

  logic in_accept, s1_go, s1_result, s1_in_range, out_free;
  logic [IDX_W-1:0] s1_idx;

  assign in_accept   = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign s1_in_range = (32'(s1_chan) < NUM_CHANNELS);
  assign s1_result   = (s1_action == ACT_FILTER) && s1_in_range;
  assign s1_go       = s1_valid && (!s1_result || out_free);
  assign in_stall    = s1_valid && !s1_go;
  assign s1_idx      = IDX_W'(s1_chan);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action <= action;
      s1_chan   <= channel;
      s1_sample <= sample_in;
    end
  end

  // per-channel history: x1/x2 previous inputs, y1/y2 previous outputs
  logic signed [SAMPLE_BITS-1:0] x1_hist [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2_hist [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_hist [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_hist [NUM_CHANNELS];

  logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2;

  assign x1 = x1_hist[s1_idx];
  assign x2 = x2_hist[s1_idx];
  assign y1 = y1_hist[s1_idx];
  assign y2 = y2_hist[s1_idx];

  // five products, feedback terms negated
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;

  assign p0 = PROD_W'(coef_b0) * PROD_W'(s1_sample);
  assign p1 = PROD_W'(coef_b1) * PROD_W'(x1);
  assign p2 = PROD_W'(coef_b2) * PROD_W'(x2);
  assign p3 = -(PROD_W'(coef_a1) * PROD_W'(y1));
  assign p4 = -(PROD_W'(coef_a2) * PROD_W'(y2));

  // exact sum, round half up, saturate
  logic signed [SUM_W-1:0] acc, rnd;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic clip;

  always_comb begin
    acc = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + SUM_W'(p3) + SUM_W'(p4);
    rnd = (acc + HALF) >>> COEF_FRAC_BITS;
    if (rnd > SMAX) begin
      y_sat = SAMPLE_BITS'(SMAX);
      clip  = 1'b1;
    end else if (rnd < SMIN) begin
      y_sat = SAMPLE_BITS'(SMIN);
      clip  = 1'b1;
    end else begin
      y_sat = rnd[SAMPLE_BITS-1:0];
      clip  = 1'b0;
    end
  end

  // history update as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        x1_hist[c] <= '0;
        x2_hist[c] <= '0;
        y1_hist[c] <= '0;
        y2_hist[c] <= '0;
      end
    end else if (s1_go && (s1_action == ACT_CLEAR)) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        x1_hist[c] <= '0;
        x2_hist[c] <= '0;
        y1_hist[c] <= '0;
        y2_hist[c] <= '0;
      end
    end else if (s1_go && s1_result) begin
      x1_hist[s1_idx] <= s1_sample;
      x2_hist[s1_idx] <= x1;
      y1_hist[s1_idx] <= y_sat;
      y2_hist[s1_idx] <= y1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_result) begin
      channel_out <= s1_chan;
      sample_out  <= y_sat;
      clipped     <= clip;
    end
  end

`ifndef SYNTHESIS
  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (sample_out == SAMPLE_BITS'(SMAX) || sample_out == SAMPLE_BITS'(SMIN)))
    else $error("clipped result not at a rail");

  // stall only while an item is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall without an item in the input register");

  // a clear zeroes the history
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_action == ACT_CLEAR)) |=>
      (x1_hist[0] == '0 && y1_hist[0] == '0 && y2_hist[0] == '0))
    else $error("history not cleared");

  // the delivered sample is what entered the output history
  a_hist_out: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_result) |=>
      (out_valid && sample_out == y1_hist[$past(s1_idx)]))
    else $error("output history disagrees with result");
`endif

endmodule
